// ===== rtl/core/trimmed_mean_of_scores_macros.svh =====
// assertion helpers for the trimmed mean block
`ifndef TRIMMED_MEAN_OF_SCORES_MACROS_SVH
`define TRIMMED_MEAN_OF_SCORES_MACROS_SVH

// implication checked on every edge outside reset
`define TMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tms assertion failed");

// next-cycle implication checked on every edge outside reset
`define TMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tms assertion failed");

// next-cycle implication that also holds through reset
`define TMS_ASSERT_ALW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tms assertion failed");

`endif

// ===== rtl/core/tms_pkg.sv =====
package tms_pkg;

  localparam int NUM_SCORES_DEF  = 10;
  localparam int SCORE_WIDTH_DEF = 16;
  localparam int IN_W            = 16;
  localparam int OUT_W           = 16;
  localparam int TRIM_W          = 2;
  localparam int PC_W            = 4;

  localparam logic [TRIM_W-1:0] TRIM_PRELIM = 2'd1;
  localparam logic [TRIM_W-1:0] TRIM_FINAL  = 2'd2;

  typedef enum logic [3:0] {
    OP_SORT_INIT,
    OP_RD0,
    OP_LOADRUN,
    OP_CMP,
    OP_PEND,
    OP_SUM_INIT,
    OP_SUM_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_IDX_MORE,
    C_LIM_MORE,
    C_TRIM_BAD,
    C_SUM_MORE,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } cw_t;

  typedef struct packed {
    logic load;
    logic exec;
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic idx_more;
    logic lim_more;
    logic trim_bad;
    logic sum_more;
    logic div_more;
  } status_t;

  localparam logic [PC_W-1:0] S_RD0      = 4'd1;
  localparam logic [PC_W-1:0] S_CMP      = 4'd3;
  localparam logic [PC_W-1:0] S_SUM_ACC  = 4'd6;
  localparam logic [PC_W-1:0] S_DIV_STEP = 4'd8;
  localparam logic [PC_W-1:0] S_FIN_NONE = 4'd10;

  // control store: sort by passes, trimmed sum, reciprocal multiply
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = '{op: OP_FINISH, cond: C_NEXT, target: '0, done: 1'b1};
    unique case (pc)
      4'd0:  cw = '{op: OP_SORT_INIT, cond: C_NEXT,     target: '0,         done: 1'b0};
      4'd1:  cw = '{op: OP_RD0,       cond: C_NEXT,     target: '0,         done: 1'b0};
      4'd2:  cw = '{op: OP_LOADRUN,   cond: C_NEXT,     target: '0,         done: 1'b0};
      4'd3:  cw = '{op: OP_CMP,       cond: C_IDX_MORE, target: S_CMP,      done: 1'b0};
      4'd4:  cw = '{op: OP_PEND,      cond: C_LIM_MORE, target: S_RD0,      done: 1'b0};
      4'd5:  cw = '{op: OP_SUM_INIT,  cond: C_TRIM_BAD, target: S_FIN_NONE, done: 1'b0};
      4'd6:  cw = '{op: OP_SUM_ACC,   cond: C_SUM_MORE, target: S_SUM_ACC,  done: 1'b0};
      4'd7:  cw = '{op: OP_DIV_INIT,  cond: C_NEXT,     target: '0,         done: 1'b0};
      4'd8:  cw = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: S_DIV_STEP, done: 1'b0};
      4'd9:  cw = '{op: OP_EMIT,      cond: C_NEXT,     target: '0,         done: 1'b1};
      4'd10: cw = '{op: OP_FINISH,    cond: C_NEXT,     target: '0,         done: 1'b1};
      default: cw = '{op: OP_FINISH,  cond: C_NEXT,     target: '0,         done: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/core/tms_sequencer.sv =====
module tms_sequencer #(
  parameter int NUM_SCORES = tms_pkg::NUM_SCORES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  tms_pkg::status_t              status,
  output tms_pkg::ctrl_t                ctrl,
  output logic [$clog2(NUM_SCORES)-1:0] load_addr,
  output logic                          busy
);

  localparam int CL = $clog2(NUM_SCORES);

  logic [tms_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     running_r, running_nxt;
  logic [CL-1:0]            count_r, count_nxt;
  tms_pkg::cw_t             cw;
  logic                     take;
  logic                     jump;

  assign cw   = tms_pkg::ucode(pc_r);
  assign take = start && !running_r;
  assign busy = running_r;

  always_comb begin
    unique case (cw.cond)
      tms_pkg::C_NEXT:     jump = 1'b0;
      tms_pkg::C_IDX_MORE: jump = status.idx_more;
      tms_pkg::C_LIM_MORE: jump = status.lim_more;
      tms_pkg::C_TRIM_BAD: jump = status.trim_bad;
      tms_pkg::C_SUM_MORE: jump = status.sum_more;
      tms_pkg::C_DIV_MORE: jump = status.div_more;
      default:             jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt      = pc_r;
    running_nxt = running_r;
    count_nxt   = count_r;
    if (running_r) begin
      pc_nxt = jump ? cw.target : pc_r + 1'b1;
      if (cw.done) begin
        running_nxt = 1'b0;
      end
    end else if (take) begin
      // last score of the set starts the program
      if (count_r == CL'(NUM_SCORES - 1)) begin
        count_nxt   = '0;
        running_nxt = 1'b1;
        pc_nxt      = '0;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_comb begin
    ctrl.load = take;
    ctrl.exec = running_r;
    ctrl.op   = cw.op;
    load_addr = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      running_r <= 1'b0;
      count_r   <= '0;
    end else begin
      pc_r      <= pc_nxt;
      running_r <= running_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/tms_datapath.sv =====
module tms_datapath #(
  parameter int NUM_SCORES  = tms_pkg::NUM_SCORES_DEF,
  parameter int SCORE_WIDTH = tms_pkg::SCORE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tms_pkg::ctrl_t                    ctrl,
  input  logic [$clog2(NUM_SCORES)-1:0]     load_addr,
  input  logic [tms_pkg::IN_W-1:0]          in_score,
  input  logic                              cfg_we,
  input  logic [tms_pkg::TRIM_W-1:0]        cfg_wdata,
  output tms_pkg::status_t                  status,
  output logic                              out_valid,
  output logic [tms_pkg::OUT_W-1:0]         out_mean
);

  localparam int CL     = $clog2(NUM_SCORES);
  localparam int SW     = SCORE_WIDTH;
  localparam int SUM_W  = SW + CL;
  localparam int MAG_W  = SUM_W + CL;
  localparam int DIG    = 16;
  localparam int NDIG   = (MAG_W + DIG - 1) / DIG;
  localparam int MAGP_W = NDIG * DIG;
  localparam int PROD_W = SUM_W + MAGP_W;
  localparam int PP_W   = SUM_W + DIG;
  localparam int CNT_W  = $clog2(NDIG + 1);

  // remaining counts per round and their rounded-up reciprocals
  localparam logic [63:0] DIV_PRE = 64'(NUM_SCORES) - 64'({tms_pkg::TRIM_PRELIM, 1'b0});
  localparam logic [63:0] DIV_FIN = 64'(NUM_SCORES) - 64'({tms_pkg::TRIM_FINAL, 1'b0});
  localparam logic [63:0] MAG_PRE = ((64'd1 << MAG_W) + DIV_PRE - 64'd1) / DIV_PRE;
  localparam logic [63:0] MAG_FIN = ((64'd1 << MAG_W) + DIV_FIN - 64'd1) / DIV_FIN;

  logic [SW-1:0] mem [NUM_SCORES];

  logic [SW-1:0]             rd_r;
  logic [SW-1:0]             run_r;
  logic [CL-1:0]             idx_r;
  logic [CL-1:0]             lim_r;
  logic [SUM_W-1:0]          acc_r;
  logic [SUM_W-1:0]          q_r;
  logic [MAGP_W-1:0]         mag_r;
  logic [PROD_W-1:0]         prod_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [tms_pkg::TRIM_W-1:0] trim_r;
  logic                      out_valid_r;
  logic [tms_pkg::OUT_W-1:0] out_mean_r;

  logic                      we;
  logic [CL-1:0]             wa;
  logic [SW-1:0]             wd;
  logic                      re;
  logic [CL-1:0]             ra;

  logic [SW+tms_pkg::IN_W-1:0]    score_ext;
  logic [SW-1:0]                  score_w;
  logic [SUM_W-1:0]               quot;
  logic [SUM_W+tms_pkg::OUT_W-1:0] q_ext;
  logic [CL:0]                    rem_wide;
  logic [CL-1:0]                  rem;
  logic [CL-1:0]                  hi;
  logic [MAGP_W-1:0]              mag_sel;
  logic [PP_W-1:0]                pp;
  logic                           run_gt;

  assign score_ext = {{SW{1'b0}}, in_score};
  assign score_w   = score_ext[SW-1:0];
  assign quot      = prod_r[MAG_W +: SUM_W];
  assign q_ext     = {{tms_pkg::OUT_W{1'b0}}, quot};
  assign rem_wide  = (CL+1)'(NUM_SCORES) - (CL+1)'({trim_r, 1'b0});
  assign rem       = rem_wide[CL-1:0];
  assign hi        = CL'(NUM_SCORES - 1) - CL'(trim_r);
  assign mag_sel   = (trim_r == tms_pkg::TRIM_FINAL) ? MAGP_W'(MAG_FIN) : MAGP_W'(MAG_PRE);
  assign pp        = PP_W'(q_r) * PP_W'(mag_r[MAGP_W-1 -: DIG]);
  assign run_gt    = run_r > rd_r;

  always_comb begin
    status.idx_more = ({1'b0, idx_r} + 1'b1) < {1'b0, lim_r};
    status.lim_more = lim_r > CL'(1);
    status.trim_bad = !(trim_r == tms_pkg::TRIM_PRELIM || trim_r == tms_pkg::TRIM_FINAL);
    status.sum_more = idx_r < hi;
    status.div_more = cnt_r != CNT_W'(1);
  end

  // store port control
  always_comb begin
    we = 1'b0;
    wa = load_addr;
    wd = score_w;
    re = 1'b0;
    ra = '0;
    if (ctrl.load) begin
      we = 1'b1;
    end else if (ctrl.exec) begin
      unique case (ctrl.op)
        tms_pkg::OP_RD0: begin
          re = 1'b1;
        end
        tms_pkg::OP_LOADRUN: begin
          re = 1'b1;
          ra = idx_r + 1'b1;
        end
        tms_pkg::OP_CMP: begin
          // smaller value settles at idx, larger one rides on
          we = 1'b1;
          wa = idx_r;
          wd = run_gt ? rd_r : run_r;
          re = status.idx_more;
          ra = idx_r + CL'(2);
        end
        tms_pkg::OP_PEND: begin
          we = 1'b1;
          wa = lim_r;
          wd = run_r;
        end
        tms_pkg::OP_SUM_INIT: begin
          re = 1'b1;
          ra = CL'(trim_r);
        end
        tms_pkg::OP_SUM_ACC: begin
          re = status.sum_more;
          ra = idx_r + 1'b1;
        end
        default: begin
          re = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      case (ctrl.op)
        tms_pkg::OP_SORT_INIT: lim_r <= CL'(NUM_SCORES - 1);
        tms_pkg::OP_RD0:       idx_r <= '0;
        tms_pkg::OP_LOADRUN:   run_r <= rd_r;
        tms_pkg::OP_CMP: begin
          if (!run_gt) begin
            run_r <= rd_r;
          end
          idx_r <= idx_r + 1'b1;
        end
        tms_pkg::OP_PEND:      lim_r <= lim_r - 1'b1;
        tms_pkg::OP_SUM_INIT: begin
          acc_r <= '0;
          idx_r <= CL'(trim_r);
        end
        tms_pkg::OP_SUM_ACC: begin
          acc_r <= acc_r + SUM_W'(rd_r);
          idx_r <= idx_r + 1'b1;
        end
        tms_pkg::OP_DIV_INIT: begin
          // add half the divisor so the quotient rounds to nearest
          q_r    <= acc_r + SUM_W'(rem >> 1);
          prod_r <= '0;
          mag_r  <= mag_sel;
          cnt_r  <= CNT_W'(NDIG);
        end
        tms_pkg::OP_DIV_STEP: begin
          // multiply by the reciprocal one 16-bit digit at a time, top digit first
          prod_r <= (prod_r << DIG) + PROD_W'(pp);
          mag_r  <= mag_r << DIG;
          cnt_r  <= cnt_r - 1'b1;
        end
        tms_pkg::OP_EMIT:      out_mean_r <= q_ext[tms_pkg::OUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      trim_r      <= tms_pkg::TRIM_PRELIM;
    end else begin
      out_valid_r <= ctrl.exec && (ctrl.op == tms_pkg::OP_EMIT);
      if (cfg_we) begin
        trim_r <= cfg_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;

endmodule

// ===== rtl/core/trimmed_mean_of_scores.sv =====
// channel   ports                          width   timing
// request   start / busy, in_score         16      taken when start && !busy
// result    out_valid, out_mean            16      one-cycle strobe, no stall
// config    cfg_we, cfg_wdata (trim count) 2       written on any cfg_we edge
//
// scores load one per cycle while busy is low; the set's last score raises busy for
//   the sort, the trimmed sum and the reciprocal multiply, until the mean is emitted
// an unused trim code ends the run after the sort with no result
// out_valid rises in the same cycle busy falls; the receiver cannot stall
// reset (rst_n low, synchronous) empties the set and sets trim count to 1
module trimmed_mean_of_scores #(
  parameter int NUM_SCORES  = tms_pkg::NUM_SCORES_DEF,
  parameter int SCORE_WIDTH = tms_pkg::SCORE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tms_pkg::IN_W-1:0]    in_score,
  output logic                        out_valid,
  output logic [tms_pkg::OUT_W-1:0]   out_mean,
  input  logic                        cfg_we,
  input  logic [tms_pkg::TRIM_W-1:0]  cfg_wdata
);

  tms_pkg::ctrl_t                ctrl;
  tms_pkg::status_t              status;
  logic [$clog2(NUM_SCORES)-1:0] load_addr;

  tms_sequencer #(
    .NUM_SCORES(NUM_SCORES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .status   (status),
    .ctrl     (ctrl),
    .load_addr(load_addr),
    .busy     (busy)
  );

  tms_datapath #(
    .NUM_SCORES (NUM_SCORES),
    .SCORE_WIDTH(SCORE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .load_addr(load_addr),
    .in_score (in_score),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .status   (status),
    .out_valid(out_valid),
    .out_mean (out_mean)
  );

endmodule

// ===== rtl/core/tms_checker.sv =====
`include "trimmed_mean_of_scores_macros.svh"

module tms_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // a mean shows in the cycle right after the run ends
  `TMS_ASSERT_IMP(a_out_after_run, clk, rst_n, out_valid, !busy && $past(busy))

  // out_valid never stays high back to back, so each mean is a lone strobe
  `TMS_ASSERT_NXT(a_out_single, clk, rst_n, out_valid, !out_valid)

  // a run only starts from an accepted request
  `TMS_ASSERT_IMP(a_busy_cause, clk, rst_n, $rose(busy), $past(start))

  // reset leaves the block idle and quiet
  `TMS_ASSERT_ALW(a_reset_idle, clk, !rst_n, !busy && !out_valid)

endmodule

bind trimmed_mean_of_scores tms_checker u_tms_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid)
);
